// File: src/cbs_pkg.sv
// Package: shared types and constants for the cooling boot sequencer.
`timescale 1ns / 1ps

package cbs_pkg;

    // Boot steps
    localparam logic [2:0] STEP_IDLE    = 3'd0;
    localparam logic [2:0] STEP_SENSOR  = 3'd1;
    localparam logic [2:0] STEP_PUMP    = 3'd2;
    localparam logic [2:0] STEP_FANS    = 3'd3;
    localparam logic [2:0] STEP_PSU     = 3'd4;
    localparam logic [2:0] STEP_DISPLAY = 3'd5;
    localparam logic [2:0] STEP_RUN     = 3'd6;

    // Status / finished codes
    localparam logic [1:0] STATUS_BOOTING = 2'd0;
    localparam logic [1:0] STATUS_RUN     = 2'd1;
    localparam logic [1:0] STATUS_FAULT   = 2'd2;

    // Failed channel codes
    localparam logic [2:0] CH_NONE = 3'd0;
    localparam logic [2:0] CH_PUMP = 3'd1;
    localparam logic [2:0] CH_MAIN = 3'd2;
    localparam logic [2:0] CH_PSU  = 3'd3;
    localparam logic [2:0] CH_AUX  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_PUMP_STALL   = 3'd0;
    localparam logic [2:0] CFG_FAN_STALL    = 3'd1;
    localparam logic [2:0] CFG_AUX_STALL    = 3'd2;
    localparam logic [2:0] CFG_SPINUP       = 3'd3;
    localparam logic [2:0] CFG_STEP_TIMEOUT = 3'd4;
    localparam logic [2:0] CFG_IGNORE_MASK  = 3'd5;
    localparam logic [2:0] CFG_PSU_MONITOR  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Valid thermistor reading window
    localparam logic [11:0] ADC_MIN = 12'd10;
    localparam logic [11:0] ADC_MAX = 12'd4085;

    localparam logic [15:0] STEP_TIMEOUT_RESET = 16'd5000;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        restart;
        logic [11:0] water_adc;
        logic [11:0] led_adc;
        logic [15:0] pump_rpm;
        logic [15:0] main_fan_rpm;
        logic [15:0] psu_fan_rpm;
        logic [15:0] aux_fan_rpm;
    } poll_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] boot_step;
        logic [2:0] fault_step;
        logic [2:0] failed_channel;
        logic       pump_spinup_cmd;
        logic       fans_spinup_cmd;
    } result_t;

    typedef struct packed {
        logic [15:0] pump_min_rpm;
        logic [15:0] fan_stall_rpm;
        logic [15:0] aux_min_rpm;
        logic [15:0] spin_wait_ms;
        logic [15:0] step_timeout_ms;
        logic [3:0]  ignore_mask;
        logic        psu_fan_monitor;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  step;
        logic [31:0] step_entry_time;
        logic        pump_armed;
        logic [31:0] pump_start_time;
        logic        fans_armed;
        logic [31:0] fans_start_time;
        logic [1:0]  finished;
    } seq_state_t;

endpackage

// File: src/cbs_core.sv
// Sequencer step logic: next state and result for one poll.
`timescale 1ns / 1ps

module cbs_core (
    input  cbs_pkg::cfg_t       cfg_i,
    input  cbs_pkg::seq_state_t state_i,
    input  cbs_pkg::poll_t      poll_i,
    output cbs_pkg::seq_state_t state_o,
    output cbs_pkg::result_t    result_o
);
    import cbs_pkg::*;

    function automatic logic adc_ok(input logic [11:0] v);
        adc_ok = (v >= ADC_MIN) && (v <= ADC_MAX);
    endfunction

    seq_state_t  cur;
    seq_state_t  nxt;
    result_t     res;
    logic        fault;
    logic        timed;
    logic [2:0]  fstep;
    logic [2:0]  chan;
    logic [31:0] pump_el;
    logic [31:0] fans_el;
    logic [31:0] step_el;
    logic        main_bad;
    logic        psu_bad;
    logic        aux_bad;
    logic        pump_bad;

    // Per-channel stall flags, masked by ignore bits
    assign pump_bad = !cfg_i.ignore_mask[0] && (poll_i.pump_rpm <= cfg_i.pump_min_rpm);
    assign main_bad = !cfg_i.ignore_mask[1] && (poll_i.main_fan_rpm <= cfg_i.fan_stall_rpm);
    assign psu_bad  = cfg_i.psu_fan_monitor && !cfg_i.ignore_mask[2]
                      && (poll_i.psu_fan_rpm <= cfg_i.fan_stall_rpm);
    assign aux_bad  = !cfg_i.ignore_mask[3] && (poll_i.aux_fan_rpm <= cfg_i.aux_min_rpm);

    always_comb begin
        cur = state_i;
        if (poll_i.restart) begin
            cur = '0;
        end
        nxt     = cur;
        res     = '0;
        fault   = 1'b0;
        timed   = 1'b1;
        fstep   = STEP_IDLE;
        chan    = CH_NONE;
        pump_el = '0;
        fans_el = '0;
        step_el = '0;

        if (cur.finished != STATUS_BOOTING) begin
            // Sequence over: repeat the outcome
            res.status     = cur.finished;
            res.boot_step  = cur.step;
            res.fault_step = (cur.finished == STATUS_FAULT) ? cur.step : STEP_IDLE;
        end else begin
            if (nxt.step == STEP_IDLE) begin
                nxt.step            = STEP_SENSOR;
                nxt.step_entry_time = poll_i.now_ms;
            end

            case (nxt.step)
                STEP_SENSOR: begin
                    if (adc_ok(poll_i.water_adc) && adc_ok(poll_i.led_adc)) begin
                        nxt.step_entry_time = poll_i.now_ms;
                        nxt.step            = STEP_PUMP;
                    end
                end
                STEP_PUMP: begin
                    if (!nxt.pump_armed) begin
                        nxt.pump_armed      = 1'b1;
                        nxt.pump_start_time = poll_i.now_ms;
                        res.pump_spinup_cmd = 1'b1;
                    end
                    if (!nxt.fans_armed) begin
                        nxt.fans_armed      = 1'b1;
                        nxt.fans_start_time = poll_i.now_ms;
                        res.fans_spinup_cmd = 1'b1;
                    end
                    pump_el = poll_i.now_ms - nxt.pump_start_time;
                    if (cfg_i.ignore_mask[0]
                        || ((pump_el >= {16'd0, cfg_i.spin_wait_ms})
                            && (poll_i.pump_rpm > cfg_i.pump_min_rpm))) begin
                        nxt.step_entry_time = poll_i.now_ms;
                        nxt.step            = STEP_FANS;
                    end
                end
                STEP_FANS: begin
                    if (!nxt.fans_armed) begin
                        nxt.fans_armed      = 1'b1;
                        nxt.fans_start_time = poll_i.now_ms;
                        res.fans_spinup_cmd = 1'b1;
                    end
                    fans_el = poll_i.now_ms - nxt.fans_start_time;
                    if ((fans_el >= {16'd0, cfg_i.spin_wait_ms})
                        && !main_bad && !psu_bad && !aux_bad) begin
                        nxt.step_entry_time = poll_i.now_ms;
                        nxt.step            = STEP_PSU;
                    end
                end
                STEP_PSU: begin
                    nxt.step_entry_time = poll_i.now_ms;
                    nxt.step            = STEP_DISPLAY;
                end
                STEP_DISPLAY: begin
                    nxt.step_entry_time = poll_i.now_ms;
                    nxt.step            = STEP_RUN;
                end
                STEP_RUN: begin
                    res.status   = STATUS_RUN;
                    nxt.finished = STATUS_RUN;
                end
                default: begin
                    // unreachable step code: immediate fault, no timeout check
                    timed = 1'b0;
                    fault = 1'b1;
                    fstep = nxt.step;
                end
            endcase

            // Timeout is judged after the step action, on the updated step
            step_el = poll_i.now_ms - nxt.step_entry_time;
            if (timed && (step_el > {16'd0, cfg_i.step_timeout_ms})) begin
                fault = 1'b1;
                fstep = nxt.step;
                if (nxt.step == STEP_PUMP) begin
                    chan = pump_bad ? CH_PUMP : CH_NONE;
                end else if (nxt.step == STEP_FANS) begin
                    if (main_bad) begin
                        chan = CH_MAIN;
                    end else if (psu_bad) begin
                        chan = CH_PSU;
                    end else if (aux_bad) begin
                        chan = CH_AUX;
                    end
                end
            end

            if (fault) begin
                res.status         = STATUS_FAULT;
                nxt.finished       = STATUS_FAULT;
                res.fault_step     = fstep;
                res.failed_channel = chan;
            end
            res.boot_step = nxt.step;
        end
    end

    assign state_o  = nxt;
    assign result_o = res;

endmodule

// File: src/cooling_boot_sequencer_unit.sv
// Top level: cooling fan/pump power-up sequencer with config port.
// A poll waits in the input register until the result register (m_*) is free or
// draining. Throughput: one poll per cycle unless the result channel stalls.
// A stalled result holds m_data while one further poll waits in the input register.
// Reset (aresetn low, synchronous): pipeline empty, sequence cleared to step 0,
// config back to defaults (timeout 5000 ms, psu fan monitored, rest zero).
`timescale 1ns / 1ps

module cooling_boot_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // poll channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cbs_pkg::poll_t                  s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output cbs_pkg::result_t                m_data,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cbs_pkg::*;

    // Input register stage
    logic       in_valid_reg;
    poll_t      in_data_reg;
    // Result register stage
    logic       out_valid_reg;
    result_t    out_data_reg;
    // Sequencer state and configuration
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    result_next;
    cfg_t       cfg_reg;
    logic       advance;

    // A poll moves from the input register into the result register (and
    // commits its state update) whenever the result slot is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    // The user must send config writes only while idle; the block does not enforce it, so they are always taken.
    assign cfg_ready = 1'b1;

    cbs_core u_core (
        .cfg_i    (cfg_reg),
        .state_i  (state_reg),
        .poll_i   (in_data_reg),
        .state_o  (state_next),
        .result_o (result_next)
    );

    // Handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // Sequencer state: updated once per poll transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pump_min_rpm    <= '0;
            cfg_reg.fan_stall_rpm   <= '0;
            cfg_reg.aux_min_rpm     <= '0;
            cfg_reg.spin_wait_ms    <= '0;
            cfg_reg.step_timeout_ms <= STEP_TIMEOUT_RESET;
            cfg_reg.ignore_mask     <= '0;
            cfg_reg.psu_fan_monitor <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PUMP_STALL:   cfg_reg.pump_min_rpm    <= cfg_data;
                CFG_FAN_STALL:    cfg_reg.fan_stall_rpm   <= cfg_data;
                CFG_AUX_STALL:    cfg_reg.aux_min_rpm     <= cfg_data;
                CFG_SPINUP:       cfg_reg.spin_wait_ms    <= cfg_data;
                CFG_STEP_TIMEOUT: cfg_reg.step_timeout_ms <= cfg_data;
                CFG_IGNORE_MASK:  cfg_reg.ignore_mask     <= cfg_data[3:0];
                CFG_PSU_MONITOR:  cfg_reg.psu_fan_monitor <= cfg_data[0];
                default: begin
                    // index outside the register list: ignored
                end
            endcase
        end
    end

endmodule

// File: src/cbs_checker.sv
// Checker: port-level properties of the sequencer, bound to the top level.
`timescale 1ns / 1ps

module cbs_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input cbs_pkg::result_t m_data
);
    import cbs_pkg::*;

    // A stalled result transaction keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Fault step and channel only accompany a fault
    a_no_fault_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_FAULT |->
            m_data.fault_step == STEP_IDLE && m_data.failed_channel == CH_NONE)
        else $error("fault fields set without fault");

    // A fault always names a real step
    a_fault_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FAULT |-> m_data.fault_step != STEP_IDLE)
        else $error("fault without a step");

    // Run is only entered from the last step
    a_run_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_RUN |-> m_data.boot_step == STEP_RUN)
        else $error("run status outside final step");

    // Spin-up commands only while booting
    a_cmd_booting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.pump_spinup_cmd || m_data.fans_spinup_cmd) |->
            m_data.status != STATUS_RUN && m_data.boot_step != STEP_IDLE)
        else $error("spin-up command outside boot");

endmodule

bind cooling_boot_sequencer_unit cbs_checker u_cbs_checker (.*);

// File: sim/cbs_boot_checker.sv
// Checker: watches the poll, result and register channels and predicts each result.
`timescale 1ns / 1ps

module cbs_boot_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  cbs_pkg::poll_t                  s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  cbs_pkg::result_t                m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              runs_seen,
    output int                              faults_seen
);
    import cbs_pkg::*;

    cfg_t       cfg;
    seq_state_t seq;
    result_t    boot_results_due[$];
    result_t    want;
    logic [1:0] prior_done;

    int fail_total = 0;
    int owed       = 0;
    int runs_n     = 0;
    int faults_n   = 0;

    assign errors      = fail_total;
    assign pending     = owed;
    assign runs_seen   = runs_n;
    assign faults_seen = faults_n;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got_v,
                               input logic [7:0] want_v);
        if (got_v !== want_v)
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
    endtask

    function automatic logic adc_in_window(input logic [11:0] v);
        return v >= ADC_MIN && v <= ADC_MAX;
    endfunction

    function automatic void enter_step(input logic [31:0] t, input logic [2:0] nxt);
        seq.step_entry_time = t;
        seq.step            = nxt;
    endfunction

    // One poll through the sequencer; updates the shadow sequence state.
    task automatic predict_boot_poll(input poll_t p, output result_t r);
        logic        fault;
        logic        fans_ok;
        logic [31:0] elapsed;
        r     = '0;
        fault = 1'b0;
        if (p.restart)
            seq = '0;
        if (seq.finished != STATUS_BOOTING) begin
            // sequence over: echo the final state
            r.status     = seq.finished;
            r.boot_step  = seq.step;
            r.fault_step = (seq.finished == STATUS_FAULT) ? seq.step : STEP_IDLE;
            return;
        end
        if (seq.step == STEP_IDLE)
            enter_step(p.now_ms, STEP_SENSOR);
        case (seq.step)
            STEP_SENSOR: begin
                if (adc_in_window(p.water_adc) && adc_in_window(p.led_adc))
                    enter_step(p.now_ms, STEP_PUMP);
            end
            STEP_PUMP: begin
                if (!seq.pump_armed) begin
                    seq.pump_armed      = 1'b1;
                    seq.pump_start_time = p.now_ms;
                    r.pump_spinup_cmd   = 1'b1;
                end
                if (!seq.fans_armed) begin
                    seq.fans_armed      = 1'b1;
                    seq.fans_start_time = p.now_ms;
                    r.fans_spinup_cmd   = 1'b1;
                end
                elapsed = p.now_ms - seq.pump_start_time;
                if (cfg.ignore_mask[0] ||
                    (elapsed >= {16'd0, cfg.spin_wait_ms} && p.pump_rpm > cfg.pump_min_rpm))
                    enter_step(p.now_ms, STEP_FANS);
            end
            STEP_FANS: begin
                if (!seq.fans_armed) begin
                    seq.fans_armed      = 1'b1;
                    seq.fans_start_time = p.now_ms;
                    r.fans_spinup_cmd   = 1'b1;
                end
                elapsed = p.now_ms - seq.fans_start_time;
                if (elapsed >= {16'd0, cfg.spin_wait_ms}) begin
                    fans_ok = (cfg.ignore_mask[1] || p.main_fan_rpm > cfg.fan_stall_rpm) &&
                              (!cfg.psu_fan_monitor || cfg.ignore_mask[2] ||
                               p.psu_fan_rpm > cfg.fan_stall_rpm) &&
                              (cfg.ignore_mask[3] || p.aux_fan_rpm > cfg.aux_min_rpm);
                    if (fans_ok)
                        enter_step(p.now_ms, STEP_PSU);
                end
            end
            STEP_PSU:     enter_step(p.now_ms, STEP_DISPLAY);
            STEP_DISPLAY: enter_step(p.now_ms, STEP_RUN);
            STEP_RUN: begin
                r.status     = STATUS_RUN;
                seq.finished = STATUS_RUN;
            end
            default: begin
                // bad step: immediate fault, no timeout check
                fault        = 1'b1;
                r.fault_step = seq.step;
            end
        endcase
        if (!fault) begin
            elapsed = p.now_ms - seq.step_entry_time;
            if (elapsed > {16'd0, cfg.step_timeout_ms}) begin
                fault        = 1'b1;
                r.fault_step = seq.step;
                if (seq.step == STEP_PUMP) begin
                    if (!cfg.ignore_mask[0] && p.pump_rpm <= cfg.pump_min_rpm)
                        r.failed_channel = CH_PUMP;
                end else if (seq.step == STEP_FANS) begin
                    if (!cfg.ignore_mask[1] && p.main_fan_rpm <= cfg.fan_stall_rpm)
                        r.failed_channel = CH_MAIN;
                    else if (cfg.psu_fan_monitor && !cfg.ignore_mask[2] &&
                             p.psu_fan_rpm <= cfg.fan_stall_rpm)
                        r.failed_channel = CH_PSU;
                    else if (!cfg.ignore_mask[3] && p.aux_fan_rpm <= cfg.aux_min_rpm)
                        r.failed_channel = CH_AUX;
                end
            end
        end
        if (fault) begin
            r.status     = STATUS_FAULT;
            seq.finished = STATUS_FAULT;
        end
        r.boot_step = seq.step;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg                 = '0;
            cfg.step_timeout_ms = STEP_TIMEOUT_RESET;
            cfg.psu_fan_monitor = 1'b1;
            seq                 = '0;
            boot_results_due.delete();
            owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PUMP_STALL:   cfg.pump_min_rpm    = cfg_data;
                    CFG_FAN_STALL:    cfg.fan_stall_rpm   = cfg_data;
                    CFG_AUX_STALL:    cfg.aux_min_rpm     = cfg_data;
                    CFG_SPINUP:       cfg.spin_wait_ms    = cfg_data;
                    CFG_STEP_TIMEOUT: cfg.step_timeout_ms = cfg_data;
                    CFG_IGNORE_MASK:  cfg.ignore_mask     = cfg_data[3:0];
                    CFG_PSU_MONITOR:  cfg.psu_fan_monitor = cfg_data[0];
                    default: ;
                endcase
            end
            // results leave before this edge's poll could produce one
            if (m_valid && m_ready) begin
                if (boot_results_due.size() == 0) begin
                    flag_mismatch("result transaction with nothing due");
                end else begin
                    want = boot_results_due.pop_front();
                    check_field("status", 8'(m_data.status), 8'(want.status));
                    check_field("boot_step", 8'(m_data.boot_step), 8'(want.boot_step));
                    check_field("fault_step", 8'(m_data.fault_step), 8'(want.fault_step));
                    check_field("failed_channel", 8'(m_data.failed_channel),
                                8'(want.failed_channel));
                    check_field("pump_spinup_cmd", 8'(m_data.pump_spinup_cmd),
                                8'(want.pump_spinup_cmd));
                    check_field("fans_spinup_cmd", 8'(m_data.fans_spinup_cmd),
                                8'(want.fans_spinup_cmd));
                end
            end
            if (s_valid && s_ready) begin
                prior_done = seq.finished;
                predict_boot_poll(s_data, want);
                if (seq.finished != STATUS_BOOTING &&
                    (s_data.restart || prior_done == STATUS_BOOTING)) begin
                    if (seq.finished == STATUS_RUN)
                        runs_n++;
                    else
                        faults_n++;
                end
                boot_results_due.push_back(want);
            end
            owed <= boot_results_due.size();
        end
    end

endmodule

// File: sim/cooling_boot_sequencer_unit_tb.sv
// Testbench top: clock, reset, poll and register stimulus, result sink and verdict.
`timescale 1ns / 1ps

module cooling_boot_sequencer_unit_tb;
    import cbs_pkg::*;

    localparam int N_SETTINGS   = 8;
    localparam int POLLS_PER_SETTING = 200;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    poll_t                  s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    result_t                m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PUMP_STALL;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int errors, pending, runs_seen, faults_seen;

    // No-idle stretches: when set, that side never pauses between transactions.
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;

    // Register values as last written; random stimulus is shaped around them.
    int unsigned sh_pump_stall, sh_fan_stall, sh_aux_stall, sh_tmo;

    logic [31:0] clock_ms;
    int          polls_sent = 0;
    int          settings_done = 0;

    cooling_boot_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbs_boot_checker boot_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .runs_seen   (runs_seen),
        .faults_seen (faults_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result sink: draws a stall before each transaction, then holds ready
    // until one completes. Ready and valid are sampled as they stood at the edge.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // One poll transaction. Valid is only lowered when a gap is drawn, so a
    // back-to-back poll keeps valid high with a single assignment per edge.
    task automatic offer_poll(input poll_t p);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        polls_sent++;
    endtask

    task automatic poll_at(input logic [31:0] t, input logic rst,
                           input logic [11:0] wadc, input logic [11:0] ladc,
                           input logic [15:0] pump, input logic [15:0] mainf,
                           input logic [15:0] psuf, input logic [15:0] auxf);
        poll_t p;
        p.now_ms       = t;
        p.restart      = rst;
        p.water_adc    = wadc;
        p.led_adc      = ladc;
        p.pump_rpm     = pump;
        p.main_fan_rpm = mainf;
        p.psu_fan_rpm  = psuf;
        p.aux_fan_rpm  = auxf;
        offer_poll(p);
    endtask

    // Stop sending until every result is back, then let the pipeline go quiet.
    // The count seen here is registered and trails the edge, so it is not
    // trusted until it has caught up.
    task automatic wait_until_settled();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register writes hold valid across consecutive writes; caller lowers it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_setting(input int unsigned pstall, input int unsigned fstall,
                                input int unsigned astall, input int unsigned spin,
                                input int unsigned tmo, input logic [3:0] mask,
                                input logic psu_mon);
        sh_pump_stall = pstall;
        sh_fan_stall  = fstall;
        sh_aux_stall  = astall;
        sh_tmo        = tmo;
        write_reg(CFG_PUMP_STALL, pstall[15:0]);
        write_reg(CFG_FAN_STALL, fstall[15:0]);
        write_reg(CFG_AUX_STALL, astall[15:0]);
        write_reg(CFG_SPINUP, spin[15:0]);
        write_reg(CFG_STEP_TIMEOUT, tmo[15:0]);
        write_reg(CFG_IGNORE_MASK, {12'd0, mask});
        write_reg(CFG_PSU_MONITOR, {15'd0, psu_mon});
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    function automatic int unsigned pick_stall();
        return ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 3000);
    endfunction

    // Thermistor reading: mostly inside 10..4085, sometimes on or past an edge.
    function automatic logic [11:0] pick_adc();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 12'($urandom_range(0, 9));
        if (r < 6) return 12'($urandom_range(4086, 4095));
        if (r < 8) return ($urandom_range(0, 1) == 0) ? ADC_MIN : ADC_MAX;
        return 12'($urandom_range(10, 4085));
    endfunction

    // Tach reading: mostly healthy, sometimes stalled or right at the limit.
    function automatic logic [15:0] pick_rpm(input int unsigned stall);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'($urandom_range(0, stall));
        if (r < 15) return 16'(stall);
        if (r < 20) return 16'($urandom_range(0, 65535));
        if (stall >= 65535) return 16'hFFFF;
        return 16'($urandom_range(stall + 1, 65535));
    endfunction

    // One boot attempt: a restart followed by polls with advancing time.
    // A few polls jump past the step timeout, some repeat the same ms, and a
    // small share are pure noise with a random clock.
    task automatic run_attempt();
        int          n, k, r;
        int unsigned step_max;
        poll_t       p;
        n        = $urandom_range(4, 30);
        tx_burst = ($urandom_range(0, 4) == 0);
        rx_burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 7) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * sh_tmo + 10);
        step_max = sh_tmo / 6 + 1;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                clock_ms += sh_tmo + 1 + $urandom_range(0, 500);
            else if (r >= 12)
                clock_ms += $urandom_range(1, step_max);
            p.now_ms       = clock_ms;
            p.restart      = (k == 0) || ($urandom_range(0, 49) == 0);
            p.water_adc    = pick_adc();
            p.led_adc      = pick_adc();
            p.pump_rpm     = pick_rpm(sh_pump_stall);
            p.main_fan_rpm = pick_rpm(sh_fan_stall);
            p.psu_fan_rpm  = pick_rpm(sh_fan_stall);
            p.aux_fan_rpm  = pick_rpm(sh_aux_stall);
            if ($urandom_range(0, 19) == 0) begin
                p.now_ms       = $urandom;
                p.restart      = 1'($urandom_range(0, 1));
                p.water_adc    = 12'($urandom_range(0, 4095));
                p.led_adc      = 12'($urandom_range(0, 4095));
                p.pump_rpm     = 16'($urandom_range(0, 65535));
                p.main_fan_rpm = 16'($urandom_range(0, 65535));
                p.psu_fan_rpm  = 16'($urandom_range(0, 65535));
                p.aux_fan_rpm  = 16'($urandom_range(0, 65535));
            end
            offer_poll(p);
        end
    endtask

    initial begin
        int          ph, guard, r;
        int unsigned tmo;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----------------------------------------------
        // stall 100/100/50, spin-up 20 ms, step timeout 1000 ms, all monitored
        load_setting(100, 100, 50, 20, 1000, 4'h0, 1'b1);

        // sensor window edges, then a full clean boot through every step
        poll_at(32'd1000, 1'b1, 12'd9,    12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1001, 1'b0, 12'd2000, 12'd4086, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1002, 1'b0, 12'd10,   12'd4085, 16'd0, 16'd0, 16'd0, 16'd0);
        // first poll in the pump step arms both spin-ups
        poll_at(32'd1003, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        // pump exactly at its stall limit does not pass; one above does
        poll_at(32'd1023, 1'b0, 12'd2000, 12'd2000, 16'd100, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1023, 1'b0, 12'd2000, 12'd2000, 16'd101, 16'd0, 16'd0, 16'd0);
        // each fan stalled in turn, then all healthy
        poll_at(32'd1030, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0,   16'd200, 16'd200);
        poll_at(32'd1031, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd101, 16'd100, 16'd200);
        poll_at(32'd1032, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd101, 16'd101, 16'd50);
        poll_at(32'd1033, 1'b0, 12'd2000, 12'd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        poll_at(32'd1034, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1035, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1036, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        // after entry to run the state just repeats
        poll_at(32'd1037, 1'b0, 12'd0,    12'd0,    16'd0, 16'd0, 16'd0, 16'd0);
        // restart just below the clock wrap; pump times out across the wrap
        poll_at(32'hFFFF_FFF0, 1'b1, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'hFFFF_FFF5, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'h0000_0500, 1'b0, 12'd2000, 12'd2000, 16'd5, 16'd0, 16'd0, 16'd0);
        // sensor step: exactly at the timeout is fine, one ms later faults
        poll_at(32'd5000, 1'b1, 12'd0,    12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd6000, 1'b0, 12'd0,    12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd6001, 1'b0, 12'd4095, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        // timeout in the run-entry step overrides entering run
        poll_at(32'd200,  1'b1, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd201,  1'b0, 12'd2000, 12'd2000, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        poll_at(32'd221,  1'b0, 12'd2000, 12'd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        poll_at(32'd221,  1'b0, 12'd2000, 12'd2000, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        poll_at(32'd222,  1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd223,  1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        poll_at(32'd1224, 1'b0, 12'd2000, 12'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
        wait_until_settled();

        // ---- random part, one register setting per phase ----------------
        for (ph = 0; ph < N_SETTINGS; ph++) begin
            if (ph == 0) begin
                // all limits at zero, longest timeout
                load_setting(0, 0, 0, 0, 65535, 4'h0, 1'b1);
            end else if (ph == 1) begin
                // limits at maximum, zero timeout, every channel ignored
                load_setting(65535, 65535, 65535, 65535, 0, 4'hF, 1'b0);
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    tmo = 32'(STEP_TIMEOUT_RESET);
                else if (r == 1)
                    tmo = $urandom_range(0, 5);
                else
                    tmo = $urandom_range(20, 3000);
                load_setting(pick_stall(), pick_stall(), pick_stall(),
                             $urandom_range(0, tmo) / 2, tmo,
                             ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)));
            end
            clock_ms = $urandom;
            guard    = polls_sent + POLLS_PER_SETTING;
            while (polls_sent < guard) begin
                run_attempt();
                // now and then let the block run dry before the next attempt
                if ($urandom_range(0, 9) == 0)
                    wait_until_settled();
            end
            wait_until_settled();
        end

        // ---- end of run -------------------------------------------------
        guard = 0;
        while (pending != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (pending != 0)
            $display("results never returned: %0d", pending);
        $display("ran %0d polls under %0d register settings", polls_sent, settings_done);
        $display("boots reaching run: %0d, boots ending in fault: %0d", runs_seen, faults_seen);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
